// ===== rtl/tse_pkg.sv =====
// Shared types and constants for the Taylor series evaluator.
// No dependencies.
package tse_pkg;

  localparam int NUM_TERMS = 100;
  localparam int IDX_W     = 7;

  localparam logic [1:0] FN_SIN = 2'd0;
  localparam logic [1:0] FN_COS = 2'd1;
  localparam logic [1:0] FN_EXP = 2'd2;
  localparam logic [1:0] FN_LN  = 2'd3;

  localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL_A, ST_MUL_B, ST_MUL_C, ST_SMUL,
    ST_DIV_GO, ST_DIV_WAIT, ST_ACC, ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic mul_a;
    logic mul_b;
    logic mul_c;
    logic smul;
    logic div_go;
    logic div_take;
    logic acc;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] fn;
    logic       last;
    logic       div_done;
  } sts_t;

endpackage

// ===== rtl/taylor_series_evaluator.sv =====
// Per term: a split 64x32 multiply (twice for sin and cos), a scaling multiply for ln(1+x),
// a radix-2 divide and an accumulate. A new item is accepted only while idle;
// busy stays high through the result beat.
// Result beat: valid high one cycle; the receiver cannot stall.
// Reset: rst synchronous, active high; returns to idle, clears term, sum, index and overflow.
module taylor_series_evaluator (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd,
  input  logic signed [31:0] x_value,
  output logic               valid,
  output logic signed [63:0] series_sum,
  output logic               overflow
);
  import tse_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // sequencer: one term per pass through multiply, divide, accumulate
  tse_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy),
    .valid (valid)
  );

  // arithmetic: inputs are sampled on the load command at the accepting edge
  tse_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .x_value    (x_value),
    .ctl        (ctl),
    .sts        (sts),
    .series_sum (series_sum),
    .overflow   (overflow)
  );

  // an accepted beat makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("busy not raised after accept");

  // the result strobe is a single-cycle pulse and frees the block
  a_valid_free: assert property (@(posedge clk) disable iff (rst)
    valid |=> (!valid && !busy)) else $error("result strobe not followed by idle");

  // the load command only comes with an accepted beat
  a_load_src: assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> (start && !busy)) else $error("load without accept");

endmodule

// ===== rtl/tse_div.sv =====
// Radix-2 restoring divider: 64-bit magnitude by 16-bit divisor, one bit a cycle.
// Standalone; no package use.
module tse_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [15:0] divisor,
  output logic [63:0] quotient,
  output logic        done
);

  logic [15:0] rem;
  logic [15:0] dvs;
  logic [63:0] quo;
  logic [5:0]  cnt;
  logic        run;
  logic [16:0] sh;
  logic        fit;

  assign sh  = {rem, quo[63]};
  assign fit = sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && (cnt == 6'd63);
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (run) begin
      rem <= fit ? 16'(sh - {1'b0, dvs}) : sh[15:0];
      quo <= {quo[62:0], fit};
    end
  end

  assign quotient = quo;

endmodule

// ===== rtl/tse_datapath.sv =====
// Datapath: term, sum and flag registers, split 64x32 multiply, divider.
// Uses tse_pkg and tse_div.
module tse_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          cmd,
  input  logic signed [31:0]  x_value,
  input  tse_pkg::ctl_t       ctl,
  output tse_pkg::sts_t       sts,
  output logic signed [63:0]  series_sum,
  output logic                overflow
);
  import tse_pkg::*;

  logic [1:0]         fn;
  logic               xneg;
  logic [31:0]        mx;
  logic signed [63:0] term_value;
  logic signed [63:0] accumulator;
  logic [IDX_W-1:0]   term_index;
  logic               ovf;
  logic [63:0]        p_lo;
  logic [63:0]        p_hi;

  logic [63:0]        mt;
  logic               pneg;
  logic [95:0]        full;
  logic [67:0]        q;
  logic               msat;
  logic signed [63:0] mres;
  logic signed [71:0] sprod;
  logic               ssat;
  logic [13:0]        sq;
  logic [15:0]        divisor;
  logic [63:0]        quotient;
  logic               div_done;
  logic signed [63:0] t_init;
  logic               ln_out;
  logic               negate;
  logic signed [63:0] addend;
  logic               add_ovf;
  logic [64:0]        sum;
  logic               sum_ovf;
  logic signed [63:0] sum_sat;

  assign mt   = term_value[63] ? 64'(-term_value) : term_value;
  assign pneg = term_value[63] ^ xneg;

  // recombine partial products, floor toward -inf for negative results
  always_comb begin
    full = {p_hi, 32'd0} + {32'd0, p_lo};
    if (pneg) full = full + 96'h0FFF_FFFF;
    q    = full[95:28];
    msat = (q[67:64] != 4'd0) || (q[63] && (!pneg || (q[62:0] != 63'd0)));
    if (msat)      mres = pneg ? SUM_MIN : SUM_MAX;
    else if (pneg) mres = 64'(-q[63:0]);
    else           mres = q[63:0];
  end

  assign sprod = term_value * $signed({1'b0, term_index});
  assign ssat  = (sprod[71:63] != 9'h000) && (sprod[71:63] != 9'h1FF);

  always_comb begin
    sq = term_index * term_index;
    case (fn)
      FN_SIN:  divisor = {sq, 2'b00} + {8'd0, term_index, 1'b0};
      FN_COS:  divisor = {sq, 2'b00} - {8'd0, term_index, 1'b0};
      FN_EXP:  divisor = {9'd0, term_index};
      default: divisor = {9'd0, term_index} + 16'd1;
    endcase
  end

  tse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_go),
    .dividend (mt),
    .divisor  (divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  assign ln_out = (x_value >= 32'sd268435456) || (x_value <= -32'sd268435456);

  always_comb begin
    if (cmd == FN_COS || cmd == FN_EXP) t_init = 64'sd1 <<< 40;
    else                                t_init = {{20{x_value[31]}}, x_value, 12'd0};
    if (cmd == FN_LN && ln_out) t_init = '0;
  end

  always_comb begin
    negate  = term_index[0] && (fn != FN_EXP);
    add_ovf = negate && (term_value == SUM_MIN);
    if (add_ovf)     addend = SUM_MAX;
    else if (negate) addend = -term_value;
    else             addend = term_value;
    sum     = {accumulator[63], accumulator} + {addend[63], addend};
    sum_ovf = sum[64] != sum[63];
    if (sum_ovf) sum_sat = sum[64] ? SUM_MIN : SUM_MAX;
    else         sum_sat = sum[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      term_value  <= '0;
      accumulator <= '0;
      term_index  <= '0;
      ovf         <= 1'b0;
    end else begin
      if (ctl.load) begin
        fn          <= cmd;
        xneg        <= x_value[31];
        mx          <= x_value[31] ? 32'(-x_value) : x_value;
        term_value  <= t_init;
        accumulator <= t_init;
        term_index  <= IDX_W'(1);
        ovf         <= 1'b0;
      end
      if (ctl.mul_a) p_lo <= mt[31:0] * mx;
      if (ctl.mul_b) p_hi <= mt[63:32] * mx;
      if (ctl.mul_c) begin
        term_value <= mres;
        if (msat) ovf <= 1'b1;
      end
      if (ctl.smul) begin
        term_value <= ssat ? (sprod[71] ? SUM_MIN : SUM_MAX) : sprod[63:0];
        if (ssat) ovf <= 1'b1;
      end
      if (ctl.div_take) term_value <= term_value[63] ? 64'(-quotient) : quotient;
      if (ctl.acc) begin
        accumulator <= sum_sat;
        term_index  <= term_index + IDX_W'(1);
        if (add_ovf || sum_ovf) ovf <= 1'b1;
      end
    end
  end

  assign sts.fn       = fn;
  assign sts.last     = term_index == IDX_W'(NUM_TERMS - 1);
  assign sts.div_done = div_done;

  assign series_sum = accumulator;
  assign overflow   = ovf;

endmodule

// ===== rtl/tse_ctrl.sv =====
// Controller state machine: sequences multiply, divide and accumulate per term.
// Uses tse_pkg.
module tse_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  tse_pkg::sts_t sts,
  output tse_pkg::ctl_t ctl,
  output logic          busy,
  output logic          valid
);
  import tse_pkg::*;

  state_t state, state_next;
  logic   pass2, pass2_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pass2 <= 1'b0;
    end else begin
      state <= state_next;
      pass2 <= pass2_next;
    end
  end

  always_comb begin
    state_next = state;
    pass2_next = pass2;
    ctl        = '0;
    busy       = 1'b1;
    valid      = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        // load on the accepting edge itself
        if (start) begin
          ctl.load   = 1'b1;
          pass2_next = 1'b0;
          state_next = ST_MUL_A;
        end
      end
      ST_MUL_A: begin
        ctl.mul_a  = 1'b1;
        state_next = ST_MUL_B;
      end
      ST_MUL_B: begin
        ctl.mul_b  = 1'b1;
        state_next = ST_MUL_C;
      end
      ST_MUL_C: begin
        ctl.mul_c = 1'b1;
        if ((sts.fn == FN_SIN || sts.fn == FN_COS) && !pass2) begin
          pass2_next = 1'b1;
          state_next = ST_MUL_A;
        end else if (sts.fn == FN_LN) begin
          state_next = ST_SMUL;
        end else begin
          state_next = ST_DIV_GO;
        end
      end
      ST_SMUL: begin
        ctl.smul   = 1'b1;
        state_next = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        ctl.div_go = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts.div_done) begin
          ctl.div_take = 1'b1;
          state_next   = ST_ACC;
        end
      end
      ST_ACC: begin
        ctl.acc    = 1'b1;
        pass2_next = 1'b0;
        state_next = sts.last ? ST_DONE : ST_MUL_A;
      end
      ST_DONE: begin
        valid      = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
